>>> rtl/clc_pkg.sv
`default_nettype none

package clc_pkg;

    localparam int LINE_DEPTH_DEF = 256;

    localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_SPACE     = 8'h20;
    localparam logic [7:0] KEY_TILDE     = 8'h7E;

    typedef enum logic {
        CMD_KEY  = 1'b0,
        CMD_READ = 1'b1
    } t_command;

    typedef enum logic [2:0] {
        ACT_PRINT     = 3'd0,
        ACT_NEWLINE   = 3'd1,
        ACT_LEFT      = 3'd2,
        ACT_READ      = 3'd3,
        ACT_NOT_READY = 3'd4
    } t_action;

    typedef struct packed {
        logic       command;
        logic [7:0] key_code;
    } t_in_req;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_value;
        logic       last_of_run;
    } t_out_req;

endpackage

`default_nettype wire

>>> rtl/clc_line_mem.sv
`default_nettype none

module clc_line_mem
    import clc_pkg::*;
#(
    parameter int DEPTH = LINE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/clc_ctrl.sv
`default_nettype none

module clc_ctrl
    import clc_pkg::*;
#(
    parameter int DEPTH = LINE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire t_in_req       i_in_req,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output t_out_req           o_out_req,
    output logic               o_wr_en,
    output logic      [AW-1:0] o_wr_addr,
    output logic      [7:0]    o_wr_data,
    output logic               o_rd_en,
    output logic      [AW-1:0] o_rd_addr,
    input  wire logic [7:0]    i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SPACE,
        S_LEFT
    } t_state;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_complete, n_complete;
    logic          r_out_valid, n_out_valid;
    t_out_req      r_out_req, n_out_req;

    logic          out_free;
    logic          in_accept;
    logic [CW-1:0] pos_inc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign pos_inc    = r_pos + ONE_C;

    assign o_rd_addr   = r_pos[AW-1:0];
    assign o_wr_addr   = r_count[AW-1:0];
    assign o_wr_data   = i_in_req.key_code;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_complete  = r_complete;
        n_out_valid = r_out_valid;
        n_out_req   = r_out_req;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_req.command == CMD_READ) begin
                        if (!r_complete) begin
                            n_out_valid = 1'b1;
                            n_out_req   = '{ACT_NOT_READY, 8'h00, 1'b1};
                        end else begin
                            // fetch the character, answer next cycle
                            o_rd_en = 1'b1;
                            n_state = S_READ;
                            if (pos_inc >= r_count) begin
                                n_count    = '0;
                                n_pos      = '0;
                                n_complete = 1'b0;
                            end else begin
                                n_pos = pos_inc;
                            end
                        end
                    end else if (!r_complete) begin
                        case (i_in_req.key_code)
                            KEY_NEWLINE: begin
                                if (r_count < DEPTH_C) begin
                                    o_wr_en = 1'b1;
                                    n_count = r_count + ONE_C;
                                end
                                n_complete  = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_req   = '{ACT_NEWLINE, 8'h00, 1'b1};
                            end
                            KEY_BACKSPACE: begin
                                if (r_count != '0) begin
                                    n_count     = r_count - ONE_C;
                                    n_out_valid = 1'b1;
                                    n_out_req   = '{ACT_LEFT, 8'h00, 1'b0};
                                    n_state     = S_SPACE;
                                end
                            end
                            default: begin
                                if (i_in_req.key_code inside {[KEY_SPACE:KEY_TILDE]} &&
                                    (r_count < DEPTH_C - ONE_C)) begin
                                    o_wr_en     = 1'b1;
                                    n_count     = r_count + ONE_C;
                                    n_out_valid = 1'b1;
                                    n_out_req   = '{ACT_PRINT, i_in_req.key_code, 1'b1};
                                end
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_req   = '{ACT_READ, i_rd_data, 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_SPACE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_req   = '{ACT_PRINT, KEY_SPACE, 1'b0};
                    n_state     = S_LEFT;
                end
            end
            S_LEFT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_req   = '{ACT_LEFT, 8'h00, 1'b1};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_complete  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_complete  <= n_complete;
            r_out_valid <= n_out_valid;
        end
        r_out_req <= n_out_req;
    end

endmodule

`default_nettype wire

>>> rtl/console_line_editor_unit.sv
`default_nettype none

// Console line editor. Key events (command 0) edit one open line held in
// an on-chip line store of LINE_DEPTH bytes and are echoed as screen
// actions; a newline closes the line, after which read requests (command 1)
// return the stored characters one per request, newline included, and the
// line reopens empty after the last one. Requests are taken one at a time.
// A request gives one result or none if it is a key event other than a
// backspace on a non-empty line, or a read request while no line is
// complete. A backspace on a non-empty line gives three results: left,
// space, left. A read request on a complete line first reads the line
// store, whose read is registered, then gives its result. A new request
// is taken only when the output register is empty or its result leaves
// in the same cycle, so a result held by an output stall holds the input.
module console_line_editor_unit
    import clc_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_req  i_in_req,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_req      o_out_req
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    clc_ctrl #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    clc_line_mem #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire
